FILE: rtl/core/bfdh_pkg.sv
// Shared constants and types of the double-hash bloom filter core.
`timescale 1ns / 1ps
package bfdh_pkg;

    localparam int MAX_BITS    = 65536;
    localparam int MAX_PROBES  = 32;
    localparam int WORD_W      = 64;
    localparam int BIT_SEL_W   = $clog2(WORD_W);
    localparam int STORE_WORDS = MAX_BITS / WORD_W;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int HASH_W      = 64;
    localparam int DVD_W       = HASH_W - BIT_SEL_W;
    localparam int DCNT_W      = $clog2(DVD_W);
    localparam int CMD_W       = 2;
    localparam int TB_W        = 17;
    localparam int PROBE_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = TB_W;
    localparam int SUM_W       = TB_W + 1;
    localparam int SW_W        = SUM_W - BIT_SEL_W;

    localparam logic [TB_W-1:0]    TB_RESET    = TB_W'(65536);
    localparam logic [PROBE_W-1:0] PROBE_RESET = PROBE_W'(6);

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BITS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_DIV,
        S_RD,
        S_CHK
    } t_state;

endpackage

FILE: rtl/core/bfdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/bloom_filter_double_hash_core.sv
// Bloom filter core: bit store in RAM, probe positions from a shared serial divider.
// Add/query: each probe takes a 58-step bit-serial modulo, one read, and one check or
// write, then the result strobe is registered; zero probes or an unused command
// answer in the cycle after start. Clear: all 1024 RAM words, one word per cycle.
// Reset clears the store in the same sweep over all 1024 words with busy high; no result follows.
// Each result is strobed on o_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module bloom_filter_double_hash_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [bfdh_pkg::CMD_W-1:0]      i_command,
    input  logic [bfdh_pkg::HASH_W-1:0]     i_hash,
    output logic                            busy,
    output logic                            o_valid,
    output logic                            o_may_contain,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bfdh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfdh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bfdh_pkg::*;

    t_state               r_state, n_state;
    logic [TB_W-1:0]      r_total_bits;
    logic [PROBE_W-1:0]   r_probe_count;
    logic                 r_add, n_add;
    logic [HASH_W-1:0]    r_h, n_h;
    logic [HASH_W-1:0]    r_delta, n_delta;
    logic [DVD_W-1:0]     r_dvd, n_dvd;
    logic [ADDR_W-1:0]    r_rem, n_rem;
    logic [ADDR_W:0]      r_d, n_d;
    logic [DCNT_W-1:0]    r_div_n, n_div_n;
    logic [PROBE_W-1:0]   r_left, n_left;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic                 r_clr_res, n_clr_res;
    logic                 r_valid, n_valid;
    logic                 r_res, n_res;

    logic                 accept;
    logic [PROBE_W-1:0]   probes_eff;
    logic [SUM_W-1:0]     tb_sum;
    logic [SW_W-1:0]      size_words;
    logic [ADDR_W:0]      size_eff;
    logic [ADDR_W:0]      div_t;
    logic [HASH_W-1:0]    h_next;
    logic                 bit_set;
    logic                 last_probe;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [WORD_W-1:0]    ram_rdata;

    assign busy          = (r_state != S_IDLE);
    assign accept        = start && !busy;
    assign o_valid       = r_valid;
    assign o_may_contain = r_res;
    assign o_cfg_ready   = i_rst_n;

    assign probes_eff = (r_probe_count > PROBE_W'(MAX_PROBES)) ? PROBE_W'(MAX_PROBES)
                                                                : r_probe_count;
    assign tb_sum     = SUM_W'(r_total_bits) + SUM_W'(WORD_W - 1);
    assign size_words = tb_sum[SUM_W-1:BIT_SEL_W];
    always_comb begin
        if (size_words == '0) begin
            size_eff = (ADDR_W+1)'(1);
        end else if (size_words > SW_W'(STORE_WORDS)) begin
            size_eff = (ADDR_W+1)'(STORE_WORDS);
        end else begin
            size_eff = (ADDR_W+1)'(size_words);
        end
    end

    assign div_t      = {r_rem, r_dvd[DVD_W-1]};
    assign h_next     = r_h + r_delta;
    assign bit_set    = ram_rdata[r_h[BIT_SEL_W-1:0]];
    assign last_probe = (r_left == PROBE_W'(1));

    bfdh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rem),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_ADD, CMD_QUERY: begin
                            if (probes_eff != '0) begin
                                n_state = S_DIV;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                if (r_clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_div_n == '0) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if ((!r_add && !bit_set) || last_probe) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_add      = r_add;
        n_h        = r_h;
        n_delta    = r_delta;
        n_dvd      = r_dvd;
        n_rem      = r_rem;
        n_d        = r_d;
        n_div_n    = r_div_n;
        n_left     = r_left;
        n_clr_addr = r_clr_addr;
        n_clr_res  = r_clr_res;
        n_valid    = 1'b0;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_rem;
        ram_wdata  = ram_rdata | (WORD_W'(1) << r_h[BIT_SEL_W-1:0]);
        ram_re     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_add      = (t_cmd'(i_command) == CMD_ADD);
                    n_h        = i_hash;
                    n_delta    = (i_hash >> 17) | (i_hash << 15);
                    n_dvd      = i_hash[HASH_W-1:BIT_SEL_W];
                    n_rem      = '0;
                    n_d        = size_eff;
                    n_div_n    = DCNT_W'(DVD_W - 1);
                    n_left     = probes_eff;
                    n_clr_addr = '0;
                    n_clr_res  = 1'b1;
                    case (t_cmd'(i_command))
                        CMD_ADD, CMD_QUERY: begin
                            if (probes_eff == '0) begin
                                n_valid = 1'b1;
                                n_res   = 1'b1;
                            end
                        end
                        CMD_CLEAR: ;
                        default: begin
                            n_valid = 1'b1;
                            n_res   = 1'b0;
                        end
                    endcase
                end
            end
            S_CLR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STORE_WORDS - 1)) begin
                    n_valid = r_clr_res;
                    n_res   = 1'b1;
                end
            end
            S_DIV: begin
                // one restoring step of (h >> 6) mod words
                if (div_t >= r_d) begin
                    n_rem = ADDR_W'(div_t - r_d);
                end else begin
                    n_rem = div_t[ADDR_W-1:0];
                end
                n_dvd   = r_dvd << 1;
                n_div_n = r_div_n - DCNT_W'(1);
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_CHK: begin
                ram_we  = r_add;
                n_h     = h_next;
                n_dvd   = h_next[HASH_W-1:BIT_SEL_W];
                n_rem   = '0;
                n_div_n = DCNT_W'(DVD_W - 1);
                n_left  = r_left - PROBE_W'(1);
                if (!r_add && !bit_set) begin
                    n_valid = 1'b1;
                    n_res   = 1'b0;
                end else if (last_probe) begin
                    n_valid = 1'b1;
                    n_res   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_total_bits  <= TB_RESET;
            r_probe_count <= PROBE_RESET;
            r_clr_addr    <= '0;
            r_clr_res     <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_res  <= n_clr_res;
            r_valid    <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_TOTAL_BITS) begin
                    r_total_bits <= i_cfg_data[TB_W-1:0];
                end else if (i_cfg_index == REG_PROBE_COUNT) begin
                    r_probe_count <= i_cfg_data[PROBE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_add   <= n_add;
        r_h     <= n_h;
        r_delta <= n_delta;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_d     <= n_d;
        r_div_n <= n_div_n;
        r_left  <= n_left;
        r_res   <= n_res;
    end

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the double-hash bloom filter core: shadow bit store, directed and random traffic.
`timescale 1ns / 1ps
module testbench;
    import bfdh_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = 2'd3;
    localparam int                   ROT_RIGHT     = 17;
    localparam int                   ROT_LEFT      = 15;
    localparam int                   IDLE_LIMIT    = 20000;
    localparam int                   RANDOM_ITEMS  = 1400;
    localparam int                   SETTLE_CYCLES = 64;
    localparam int                   POOL_DEPTH    = 128;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic [CMD_W-1:0]      i_command;
    logic [HASH_W-1:0]     i_hash;
    logic                  busy;
    logic                  o_valid;
    logic                  o_may_contain;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bloom_filter_double_hash_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_command     (i_command),
        .i_hash        (i_hash),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_may_contain (o_may_contain),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    bit [MAX_BITS-1:0]   filter_bits;
    logic [TB_W-1:0]     size_reg;
    logic [PROBE_W-1:0]  probes_reg;
    bit                  answers_due[$];
    logic [HASH_W-1:0]   key_pool[$];
    int unsigned         error_count;
    int unsigned         idle_cycles;

    function automatic int unsigned active_size();
        int unsigned n;
        n = (int'(size_reg) + 63) & ~63;
        if (n < 64)
            n = 64;
        if (n > MAX_BITS)
            n = MAX_BITS;
        return n;
    endfunction

    // Walks the probe chain; sets bits or checks them, 0 on the first clear bit.
    function automatic bit probe_filter(input logic [HASH_W-1:0] key, input bit set_bits);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] step;
        logic [HASH_W-1:0] pos;
        int unsigned       size;
        int unsigned       count;
        int unsigned       i;
        h = key;
        size = active_size();
        count = (probes_reg > MAX_PROBES) ? MAX_PROBES : probes_reg;
        step = (h >> ROT_RIGHT) | (h << ROT_LEFT);
        for (i = 0; i < count; i++) begin
            pos = h % HASH_W'(size);
            if (set_bits) begin
                filter_bits[pos[15:0]] = 1'b1;
            end else if (!filter_bits[pos[15:0]]) begin
                return 1'b0;
            end
            h = h + step;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Checks each result beat against the oldest answer, then predicts any accepted item.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result beat with no item outstanding");
                end else begin
                    want = answers_due.pop_front();
                    if (o_may_contain !== want)
                        report_mismatch($sformatf("may_contain %b, want %b",
                                                  o_may_contain, want));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                case (i_command)
                    CMD_ADD: begin
                        void'(probe_filter(i_hash, 1'b1));
                        answers_due.push_back(1'b1);
                    end
                    CMD_QUERY: answers_due.push_back(probe_filter(i_hash, 1'b0));
                    CMD_CLEAR: begin
                        filter_bits = '0;
                        answers_due.push_back(1'b1);
                    end
                    default: answers_due.push_back(1'b0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] h);
        @(negedge i_clk);
        start = 1'b1;
        i_command = cmd;
        i_hash = h;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (cmd == CMD_ADD) begin
            key_pool.push_back(h);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        start = 1'b0;
        i_command = 2'($urandom);
        i_hash = {$urandom, $urandom};
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_TOTAL_BITS:  size_reg = data;
            REG_PROBE_COUNT: probes_reg = data[PROBE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [HASH_W-1:0] random_hash();
        return {$urandom, $urandom};
    endfunction

    task automatic test_basic_commands();
        logic [HASH_W-1:0] k;
        k = 64'h0123_4567_89ab_cdef;
        send_item(CMD_QUERY, k);
        send_item(CMD_ADD, k);
        send_item(CMD_QUERY, k);
        send_item(CMD_ADD, '1);
        send_item(CMD_QUERY, '1);
        send_item(CMD_QUERY, '0);
        send_item(CMD_ADD, '0);
        send_item(CMD_QUERY, '0);
        send_item(CMD_UNUSED, random_hash());
        send_item(CMD_CLEAR, random_hash());
        send_item(CMD_QUERY, k);
    endtask

    task automatic test_register_extremes();
        logic [HASH_W-1:0] k1;
        logic [HASH_W-1:0] k2;
        k1 = random_hash();
        k2 = random_hash();
        // zero size acts as 64 bits; zero probes always answer 1
        write_reg(REG_TOTAL_BITS, '0);
        write_reg(REG_PROBE_COUNT, '0);
        send_item(CMD_ADD, k1);
        send_item(CMD_QUERY, random_hash());
        // probe count above the maximum, upper data bits set
        write_reg(REG_PROBE_COUNT, '1);
        send_item(CMD_ADD, k1);
        send_item(CMD_QUERY, k1);
        write_reg(REG_TOTAL_BITS, '1);
        write_reg(REG_PROBE_COUNT, CFG_DATA_W'(MAX_PROBES));
        send_item(CMD_ADD, k2);
        send_item(CMD_QUERY, k2);
        write_reg(REG_TOTAL_BITS, CFG_DATA_W'(65));
        send_item(CMD_ADD, k1);
        send_item(CMD_QUERY, k2);
        // shrink without clear: old bits stay
        write_reg(REG_TOTAL_BITS, CFG_DATA_W'(64));
        send_item(CMD_QUERY, k2);
        write_reg(REG_SPARE_A, CFG_DATA_W'(5));
        write_reg(REG_SPARE_B, '0);
        send_item(CMD_QUERY, k1);
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_items;
        int unsigned done;
        int unsigned burst;
        int unsigned gap;
        int unsigned r;
        logic [CFG_DATA_W-1:0] size_data;
        logic [PROBE_W-1:0]    probe_data;
        logic [HASH_W-1:0]     h;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin size_data = '0;  probe_data = 6'd1; end
                1: begin size_data = '1;  probe_data = 6'(MAX_PROBES); end
                2: begin size_data = CFG_DATA_W'(64); probe_data = '1; end
                3: begin size_data = CFG_DATA_W'(MAX_BITS); probe_data = '0; end
                default: begin
                    size_data = ($urandom_range(0, 1) == 0) ?
                                CFG_DATA_W'($urandom_range(1, 2048)) :
                                CFG_DATA_W'($urandom_range(0, 131071));
                    probe_data = ($urandom_range(0, 7) == 0) ?
                                 PROBE_W'($urandom_range(9, 63)) :
                                 PROBE_W'($urandom_range(1, 8));
                end
            endcase
            write_reg(REG_TOTAL_BITS, size_data);
            write_reg(REG_PROBE_COUNT, {11'($urandom), probe_data});
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_CLEAR, random_hash());
            phase_items = (probe_data > 8) ? 25 : 110;
            done = 0;
            while (done < phase_items) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    r = $urandom_range(0, 99);
                    h = random_hash();
                    if (r < 40) begin
                        send_item(CMD_ADD, h);
                    end else if (r < 75 && key_pool.size() != 0) begin
                        send_item(CMD_QUERY, key_pool[$urandom_range(0, key_pool.size() - 1)]);
                    end else if (r < 85 && key_pool.size() != 0) begin
                        h = key_pool[$urandom_range(0, key_pool.size() - 1)];
                        h[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
                        send_item(CMD_QUERY, h);
                    end else if (r < 93) begin
                        send_item(CMD_QUERY, h);
                    end else if (r < 96) begin
                        send_item(CMD_UNUSED, h);
                    end else if (r < 98) begin
                        send_item(CMD_CLEAR, h);
                    end else begin
                        send_item(2'($urandom_range(0, 3)), h);
                    end
                    done++;
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain_results();
                end else begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                    if (gap != 0)
                        pause_sender(gap);
                end
            end
            sent += done;
            phase++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_ADD;
        i_hash = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TOTAL_BITS;
        i_cfg_data = '0;
        filter_bits = '0;
        size_reg = TB_RESET;
        probes_reg = PROBE_RESET;
        error_count = 0;
        idle_cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        // reset sweeps the store with busy high
        do @(posedge i_clk); while (busy !== 1'b0);

        test_basic_commands();
        test_register_extremes();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
